[rtl/fbpa_pkg.sv]
// Shared types and constants for the fixed block pool allocator.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package fbpa_pkg;

	// Pool geometry.
	localparam int NUM_BLOCKS = 1024;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = 11;
	localparam int SIZE_W     = 13;
	localparam int LIMIT_W    = SIZE_W + CNT_W;
	// A valid offset is below 4096 * NUM_BLOCKS, so it fits in 12 + IDX_W bits.
	localparam int DIV_W      = 12 + IDX_W;
	localparam int DIV_CNT_W  = $clog2(IDX_W + 1);
	localparam int OFF_W      = 22;

	localparam logic [SIZE_W-1:0] MIN_BLOCK_BYTES = SIZE_W'(8);
	localparam logic [SIZE_W-1:0] MAX_BLOCK_BYTES = SIZE_W'(4096);

	// Action codes carried on the input tuser.
	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_FREE    = 2'd1;
	localparam logic [1:0] ACT_REBUILD = 2'd2;

	// Configuration register indexes.
	localparam logic REG_BLOCK_BYTES = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_BAD_OFFSET = 2'd2,
		ST_NOTHING    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_ALLOC,
		S_ALLOC_POP,
		S_FREE_LIM,
		S_FREE_CHK,
		S_FREE_DIV,
		S_FREE_FIN,
		S_CLEAR,
		S_DONE
	} state_t;

	// Divider status seen by the sequencer.
	typedef struct packed {
		logic             busy;
		logic [IDX_W-1:0] quo;
		logic             rem_nz;
	} div_res_t;

	// Link memory access from the sequencer.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

endpackage

`default_nettype wire

[rtl/fixed_block_pool_allocator.sv]
// Fixed block pool allocator with a LIFO free list of block indices.
// Free runs a range check plus a 10-step divider; rebuild writes one link per
// cycle over the whole link RAM; one item is in work at a time, since the
// sequencer takes a new input beat only in its idle state.
// Reset: asynchronous; an init pass then writes the link RAM with s_tready low.
// Depends on fbpa_pkg, fbpa_link_ram and fbpa_divider.
`default_nettype none

module fixed_block_pool_allocator (
	input  wire          clk,
	input  wire          arst_n,
	// Input beat: tdata = offset[31:0]; tuser = action[1:0].
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [31:0]  s_tdata,
	input  wire  [1:0]   s_tuser,
	// Result beat: tdata = block_offset[21:0], free_blocks[32:22], pool_full[33],
	// pool_empty[34], alloc_total[66:35], free_total[98:67], zero pad to 103.
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [103:0] m_tdata,
	// Result tuser = status[1:0].
	output logic [1:0]   m_tuser,
	// Configuration writes.
	input  wire          wr_en,
	input  wire          wr_index,
	input  wire  [12:0]  wr_data
);

	localparam int IDX_W   = fbpa_pkg::IDX_W;
	localparam int CNT_W   = fbpa_pkg::CNT_W;
	localparam int SIZE_W  = fbpa_pkg::SIZE_W;
	localparam int LIMIT_W = fbpa_pkg::LIMIT_W;
	localparam int OFF_W   = fbpa_pkg::OFF_W;

	fbpa_pkg::state_t   state_q, state_d;
	fbpa_pkg::ram_req_t ram_req;
	fbpa_pkg::div_res_t div_res;
	fbpa_pkg::status_t  res_status_q;

	logic [SIZE_W-1:0]  block_bytes_q;
	logic [CNT_W-1:0]   block_count_q;
	logic [CNT_W-1:0]   active_q;
	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   free_cnt_q;
	logic [31:0]        alloc_tot_q;
	logic [31:0]        free_tot_q;
	logic [31:0]        off_q;
	logic [IDX_W-1:0]   clr_idx_q;
	logic [LIMIT_W-1:0] prod_q;
	logic [OFF_W-1:0]   res_off_q;
	logic               m_tvalid_q;

	logic [SIZE_W-1:0]  size_eff;
	logic [CNT_W-1:0]   count_eff;
	logic [CNT_W-1:0]   mul_b;
	logic               off_bad;
	logic               clr_last;
	logic [CNT_W-1:0]   clr_next;
	logic               div_start;
	logic               out_free;
	logic [IDX_W-1:0]   ram_rdata;

	// Clamp the configured block size and count to their legal ranges.
	always_comb begin
		size_eff = block_bytes_q;
		if (block_bytes_q < fbpa_pkg::MIN_BLOCK_BYTES) begin
			size_eff = fbpa_pkg::MIN_BLOCK_BYTES;
		end else if (block_bytes_q > fbpa_pkg::MAX_BLOCK_BYTES) begin
			size_eff = fbpa_pkg::MAX_BLOCK_BYTES;
		end
		count_eff = block_count_q;
		if (block_count_q == '0) begin
			count_eff = CNT_W'(1);
		end else if (block_count_q > CNT_W'(fbpa_pkg::NUM_BLOCKS)) begin
			count_eff = CNT_W'(fbpa_pkg::NUM_BLOCKS);
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= fbpa_pkg::MIN_BLOCK_BYTES;
			block_count_q <= CNT_W'(fbpa_pkg::NUM_BLOCKS);
		end else if (wr_en) begin
			case (wr_index)
				fbpa_pkg::REG_BLOCK_BYTES: block_bytes_q <= wr_data;
				fbpa_pkg::REG_BLOCK_COUNT: block_count_q <= wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier: block offset on allocate, pool limit on free.
	assign mul_b = (state_q == fbpa_pkg::S_ALLOC) ? CNT_W'(head_q) : active_q;

	always_ff @(posedge clk) begin
		prod_q <= LIMIT_W'(size_eff) * LIMIT_W'(mul_b);
	end

	assign off_bad  = off_q >= 32'(prod_q);
	assign clr_last = clr_idx_q == IDX_W'(fbpa_pkg::NUM_BLOCKS - 1);
	assign clr_next = CNT_W'(clr_idx_q) + CNT_W'(1);
	assign out_free = !m_tvalid_q || m_tready;

	fbpa_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (off_q[fbpa_pkg::DIV_W-1:0]),
		.divisor  (size_eff),
		.res      (div_res)
	);

	fbpa_link_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fbpa_pkg::S_INIT: begin
				if (clr_last) state_d = fbpa_pkg::S_IDLE;
			end
			fbpa_pkg::S_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						fbpa_pkg::ACT_ALLOC:   state_d = fbpa_pkg::S_ALLOC;
						fbpa_pkg::ACT_FREE:    state_d = fbpa_pkg::S_FREE_LIM;
						fbpa_pkg::ACT_REBUILD: state_d = fbpa_pkg::S_CLEAR;
						default:               state_d = fbpa_pkg::S_DONE;
					endcase
				end
			end
			fbpa_pkg::S_ALLOC: begin
				state_d = (free_cnt_q == '0) ? fbpa_pkg::S_DONE : fbpa_pkg::S_ALLOC_POP;
			end
			fbpa_pkg::S_ALLOC_POP: state_d = fbpa_pkg::S_DONE;
			fbpa_pkg::S_FREE_LIM:  state_d = fbpa_pkg::S_FREE_CHK;
			fbpa_pkg::S_FREE_CHK: begin
				state_d = off_bad ? fbpa_pkg::S_DONE : fbpa_pkg::S_FREE_DIV;
			end
			fbpa_pkg::S_FREE_DIV: begin
				if (!div_res.busy) state_d = fbpa_pkg::S_FREE_FIN;
			end
			fbpa_pkg::S_FREE_FIN: state_d = fbpa_pkg::S_DONE;
			fbpa_pkg::S_CLEAR: begin
				if (clr_last) state_d = fbpa_pkg::S_DONE;
			end
			fbpa_pkg::S_DONE: begin
				if (out_free) state_d = fbpa_pkg::S_IDLE;
			end
			default: state_d = fbpa_pkg::S_INIT;
		endcase
	end

	// Control outputs: handshake, divider start and link RAM access.
	always_comb begin
		s_tready      = state_q == fbpa_pkg::S_IDLE;
		div_start     = (state_q == fbpa_pkg::S_FREE_CHK) && !off_bad;
		ram_req.re    = state_q == fbpa_pkg::S_ALLOC;
		ram_req.raddr = head_q;
		ram_req.we    = 1'b0;
		ram_req.waddr = clr_idx_q;
		ram_req.wdata = (clr_next < active_q) ? clr_next[IDX_W-1:0] : '0;
		case (state_q)
			fbpa_pkg::S_INIT, fbpa_pkg::S_CLEAR: begin
				ram_req.we = 1'b1;
			end
			fbpa_pkg::S_FREE_FIN: begin
				ram_req.waddr = div_res.quo;
				ram_req.wdata = head_q;
				ram_req.we    = !div_res.rem_nz && (free_cnt_q < active_q);
			end
			default: ;
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbpa_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Free list state, totals and the clearing index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= CNT_W'(fbpa_pkg::NUM_BLOCKS);
			free_cnt_q  <= CNT_W'(fbpa_pkg::NUM_BLOCKS);
			head_q      <= '0;
			alloc_tot_q <= '0;
			free_tot_q  <= '0;
			clr_idx_q   <= '0;
		end else begin
			case (state_q)
				fbpa_pkg::S_INIT, fbpa_pkg::S_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
				end
				fbpa_pkg::S_IDLE: begin
					if (s_tvalid && s_tuser == fbpa_pkg::ACT_REBUILD) begin
						active_q   <= count_eff;
						free_cnt_q <= count_eff;
						head_q     <= '0;
						clr_idx_q  <= '0;
					end
				end
				fbpa_pkg::S_ALLOC_POP: begin
					head_q      <= ram_rdata;
					free_cnt_q  <= free_cnt_q - CNT_W'(1);
					alloc_tot_q <= alloc_tot_q + 32'd1;
				end
				fbpa_pkg::S_FREE_FIN: begin
					if (ram_req.we) begin
						head_q     <= div_res.quo;
						free_cnt_q <= free_cnt_q + CNT_W'(1);
						free_tot_q <= free_tot_q + 32'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// Item payload and per-item result fields.
	always_ff @(posedge clk) begin
		case (state_q)
			fbpa_pkg::S_IDLE: begin
				off_q        <= s_tdata;
				res_status_q <= fbpa_pkg::ST_OK;
				res_off_q    <= '0;
			end
			fbpa_pkg::S_ALLOC: begin
				if (free_cnt_q == '0) res_status_q <= fbpa_pkg::ST_FULL;
			end
			fbpa_pkg::S_ALLOC_POP: begin
				res_off_q <= prod_q[OFF_W-1:0];
			end
			fbpa_pkg::S_FREE_CHK: begin
				if (off_bad) res_status_q <= fbpa_pkg::ST_BAD_OFFSET;
			end
			fbpa_pkg::S_FREE_FIN: begin
				if (div_res.rem_nz) begin
					res_status_q <= fbpa_pkg::ST_BAD_OFFSET;
				end else if (free_cnt_q >= active_q) begin
					res_status_q <= fbpa_pkg::ST_NOTHING;
				end
			end
			default: ;
		endcase
	end

	// Output register: loaded when the item finishes and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == fbpa_pkg::S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fbpa_pkg::S_DONE && out_free) begin
			m_tuser <= res_status_q;
			m_tdata <= {5'd0, free_tot_q, alloc_tot_q,
				free_cnt_q == active_q, free_cnt_q == '0,
				free_cnt_q, res_off_q};
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire

[rtl/fbpa_link_ram.sv]
// Free-list link memory: one write port, one read port with registered data.
// Depends on fbpa_pkg.
`default_nettype none

module fbpa_link_ram (
	input  wire                        clk,
	input  fbpa_pkg::ram_req_t         req,
	output logic [fbpa_pkg::IDX_W-1:0] rdata
);

	logic [fbpa_pkg::IDX_W-1:0] mem [fbpa_pkg::NUM_BLOCKS];

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Read port with registered output.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/fbpa_divider.sv]
// Restoring divider, one quotient bit per cycle, for block offset checks.
// Depends on fbpa_pkg. The dividend must be below divisor * NUM_BLOCKS.
`default_nettype none

module fbpa_divider (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [fbpa_pkg::DIV_W-1:0]  dividend,
	input  wire  [fbpa_pkg::SIZE_W-1:0] divisor,
	output fbpa_pkg::div_res_t          res
);

	logic                           busy_q;
	logic [fbpa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [fbpa_pkg::DIV_W-1:0]     rem_q;
	logic [fbpa_pkg::DIV_W-1:0]     den_q;
	logic [fbpa_pkg::IDX_W-1:0]     quo_q;
	logic                           fits;

	// Trial subtraction of the shifted divisor.
	assign fits = rem_q >= den_q;

	// Control: count down one step per quotient bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= fbpa_pkg::DIV_CNT_W'(fbpa_pkg::IDX_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - fbpa_pkg::DIV_CNT_W'(1);
			busy_q <= cnt_q != fbpa_pkg::DIV_CNT_W'(1);
		end
	end

	// Datapath: remainder, shifted divisor and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			den_q <= fbpa_pkg::DIV_W'(divisor) << (fbpa_pkg::IDX_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - den_q;
			end
			quo_q <= {quo_q[fbpa_pkg::IDX_W-2:0], fits};
			den_q <= den_q >> 1;
		end
	end

	assign res.busy   = busy_q;
	assign res.quo    = quo_q;
	assign res.rem_nz = rem_q != '0;

endmodule

`default_nettype wire

[test/tb_fixed_block_pool_allocator.sv]
// Self-checking testbench for the fixed block pool allocator.
// Drives allocate, free and rebuild beats, predicts every result beat and compares it.
// Depends on fbpa_pkg and the RTL under rtl/.
module tb_fixed_block_pool_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import fbpa_pkg::*;

	localparam logic [1:0] ACT_UNUSED   = 2'd3;
	localparam int         RANDOM_ITEMS = 1630;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         CYCLE_LIMIT  = 1000000;

	// One input beat: the action on tuser and the offset on tdata.
	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] offset;
	} pool_cmd_t;

	// One result beat, split into its fields.
	typedef struct packed {
		status_t           status;
		logic [OFF_W-1:0]  blk_off;
		logic [CNT_W-1:0]  free_blocks;
		logic              full;
		logic              empty;
		logic [31:0]       alloc_tot;
		logic [31:0]       free_tot;
	} pool_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         wr_en = 1'b0;
	logic         wr_index = 1'b0;
	logic [12:0]  wr_data = '0;

	fixed_block_pool_allocator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Shadow copy of the allocator state and its registers.
	logic [CNT_W-1:0]  sh_link [NUM_BLOCKS];
	logic [CNT_W-1:0]  sh_head;
	logic [CNT_W-1:0]  sh_free;
	logic [CNT_W-1:0]  sh_active;
	logic [31:0]       sh_alloc_tot;
	logic [31:0]       sh_free_tot;
	logic [SIZE_W-1:0] sh_bytes;
	logic [CNT_W-1:0]  sh_count;

	pool_cmd_t    action_q[$];
	pool_result_t outcome_q[$];
	pool_cmd_t    on_bus;

	int cycle_count   = 0;
	int mismatches    = 0;
	int beats_sent    = 0;
	int beats_checked = 0;
	int rebuilds      = 0;
	int cfg_writes    = 0;
	int holds_done    = 0;
	int status_hits [4] = '{0, 0, 0, 0};

	// Clock: 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Block size in use: clamped to the pointer size and the page size.
	function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] bytes);
		if (bytes < MIN_BLOCK_BYTES) return MIN_BLOCK_BYTES;
		if (bytes > MAX_BLOCK_BYTES) return MAX_BLOCK_BYTES;
		return bytes;
	endfunction

	// Block count latched by a rebuild: at least one, at most the pool.
	function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] cnt);
		if (cnt == 0) return CNT_W'(1);
		if (cnt > NUM_BLOCKS) return CNT_W'(NUM_BLOCKS);
		return cnt;
	endfunction

	// Relink blocks 0..n-1 in order; the alloc and free totals are kept.
	function automatic void relink_pool();
		logic [CNT_W-1:0] n;
		n = clamp_count(sh_count);
		sh_active = n;
		for (int i = 0; i < NUM_BLOCKS; i++)
			sh_link[i] = (i + 1 < n) ? CNT_W'(i + 1) : '0;
		sh_head = '0;
		sh_free = n;
	endfunction

	// Apply one action to the shadow pool and return the result it gives.
	function automatic pool_result_t apply_action(pool_cmd_t cmd);
		pool_result_t      r;
		logic [SIZE_W-1:0] size;
		logic [63:0]       prod;
		logic [63:0]       lim;
		logic [31:0]       blk;
		size = eff_size(sh_bytes);
		r.status  = ST_OK;
		r.blk_off = '0;
		case (cmd.action)
			ACT_ALLOC: begin
				if (sh_free == 0 || sh_head >= NUM_BLOCKS) begin
					r.status = ST_FULL;
				end else begin
					prod = 64'(sh_head) * 64'(size);
					r.blk_off = prod[OFF_W-1:0];
					sh_head = sh_link[sh_head];
					sh_free = sh_free - 1'b1;
					sh_alloc_tot = sh_alloc_tot + 1;
				end
			end
			ACT_FREE: begin
				lim = 64'(size) * 64'(sh_active);
				if (64'(cmd.offset) >= lim || (cmd.offset % 32'(size)) != 0) begin
					r.status = ST_BAD_OFFSET;
				end else if (sh_free >= sh_active) begin
					r.status = ST_NOTHING;
				end else begin
					blk = cmd.offset / 32'(size);
					if (blk < NUM_BLOCKS) begin
						sh_link[blk] = sh_head;
						sh_head = blk[CNT_W-1:0];
						sh_free = sh_free + 1'b1;
						sh_free_tot = sh_free_tot + 1;
					end else begin
						r.status = ST_BAD_OFFSET;
					end
				end
			end
			ACT_REBUILD: begin
				relink_pool();
			end
			default: begin
			end
		endcase
		r.free_blocks = sh_free;
		r.full        = (sh_free == 0);
		r.empty       = (sh_free == sh_active);
		r.alloc_tot   = sh_alloc_tot;
		r.free_tot    = sh_free_tot;
		return r;
	endfunction

	// Sender: bursts of random length with random gaps; predicts at each accepted beat.
	int burst_left = 0;
	int gap_left   = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				outcome_q.push_back(apply_action(on_bus));
				beats_sent++;
				if (on_bus.action == ACT_REBUILD) rebuilds++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (action_q.size() != 0) begin
					on_bus = action_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= on_bus.offset;
					s_tuser  <= on_bus.action;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: changing stall modes, plus two long hold-offs while beats keep coming.
	int hold_left  = 0;
	int mode_left  = 0;
	int ready_mode = 0;
	int ready_tick = 0;
	logic ready_next;
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (holds_done < 2 && beats_checked >= 400 + holds_done * 700) begin
			hold_left = HOLD_CYCLES;
			holds_done++;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(16, 160);
			end else begin
				mode_left--;
			end
			ready_tick++;
			case (ready_mode)
				0: ready_next = 1'b1;
				1: ready_next = 1'($urandom_range(0, 1));
				2: ready_next = ($urandom_range(0, 7) != 0);
				default: ready_next = (ready_tick % 5 != 0);
			endcase
			m_tready <= ready_next;
		end
	end

	task automatic report(string what, longint unsigned want_v, longint unsigned got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch on %s at result %0d: expected 0x%0h, got 0x%0h",
				what, beats_checked, want_v, got_v);
	endtask

	// Monitor: compare each accepted result beat with the oldest prediction.
	pool_result_t want, got;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.status      = status_t'(m_tuser);
			got.blk_off     = m_tdata[21:0];
			got.free_blocks = m_tdata[32:22];
			got.full        = m_tdata[33];
			got.empty       = m_tdata[34];
			got.alloc_tot   = m_tdata[66:35];
			got.free_tot    = m_tdata[98:67];
			if (outcome_q.size() == 0) begin
				report("unexpected result beat", 0, m_tdata[63:0]);
			end else begin
				want = outcome_q.pop_front();
				status_hits[want.status]++;
				if (got.status !== want.status)
					report("status", want.status, got.status);
				if (got.blk_off !== want.blk_off)
					report("block_offset", want.blk_off, got.blk_off);
				if (got.free_blocks !== want.free_blocks)
					report("free_blocks", want.free_blocks, got.free_blocks);
				if (got.full !== want.full)
					report("pool_full", want.full, got.full);
				if (got.empty !== want.empty)
					report("pool_empty", want.empty, got.empty);
				if (got.alloc_tot !== want.alloc_tot)
					report("alloc_total", want.alloc_tot, got.alloc_tot);
				if (got.free_tot !== want.free_tot)
					report("free_total", want.free_tot, got.free_tot);
			end
			beats_checked++;
		end
	end

	// Watchdog on the cycle count.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding",
			cycle_count, outcome_q.size());
		$display("simulation failed");
		$finish;
	end

	task automatic write_reg(logic idx, logic [SIZE_W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_BLOCK_BYTES) sh_bytes = val;
		else sh_count = val[CNT_W-1:0];
		cfg_writes++;
	endtask

	// Wait until every queued beat is sent and every result has come back.
	// The check is made on the falling edge, once the rising-edge updates have settled.
	task automatic drain();
		while (action_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_cmd(logic [1:0] action, logic [31:0] offset);
		pool_cmd_t c;
		c.action = action;
		c.offset = offset;
		action_q.push_back(c);
	endtask

	// Offsets for a free: mostly aligned blocks in range, some out of range,
	// misaligned or wholly random.
	function automatic logic [31:0] pick_free_offset(logic [SIZE_W-1:0] size,
			logic [CNT_W-1:0] cnt);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 65)
			return 32'($urandom_range(0, cnt - 1)) * 32'(size);
		if (sel < 75)
			return (32'(cnt) + 32'($urandom_range(0, 3))) * 32'(size);
		if (sel < 85)
			return 32'($urandom_range(0, cnt - 1)) * 32'(size)
				+ 32'($urandom_range(1, size - 1));
		return $urandom();
	endfunction

	// One random phase: allocate and free with a per-phase bias, rare rebuilds and
	// unused action codes; ignored offsets are random.
	task automatic queue_random_phase(int n);
		logic [SIZE_W-1:0] size;
		logic [CNT_W-1:0]  cnt;
		int                alloc_pct;
		int                sel;
		size = eff_size(sh_bytes);
		cnt = clamp_count(sh_count);
		alloc_pct = $urandom_range(30, 70);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 2)
				queue_cmd(ACT_REBUILD, $urandom());
			else if (sel < 4)
				queue_cmd(ACT_UNUSED, $urandom());
			else if (sel < 4 + alloc_pct)
				queue_cmd(ACT_ALLOC, $urandom());
			else
				queue_cmd(ACT_FREE, pick_free_offset(size, cnt));
		end
	endtask

	function automatic logic [SIZE_W-1:0] pick_block_bytes();
		case ($urandom_range(0, 11))
			0: return 13'd0;
			1: return 13'd7;
			2: return 13'd8;
			3: return 13'd4096;
			4: return 13'd4097;
			5: return 13'd8191;
			6: return 13'd4095;
			7: return 13'd100;
			8: return 13'($urandom_range(0, 8191));
			default: return 13'(8 << $urandom_range(0, 6));
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_block_count();
		case ($urandom_range(0, 11))
			0: return 13'd0;
			1: return 13'd1024;
			2: return 13'd1025;
			3: return 13'd2047;
			4: return 13'($urandom_range(0, 8191));
			5: return 13'($urandom_range(13, 200));
			default: return 13'($urandom_range(1, 12));
		endcase
	endfunction

	// Stimulus and end of run.
	int random_items = 0;
	int phase_len;
	initial begin
		sh_bytes     = 13'd8;
		sh_count     = 11'd1024;
		sh_alloc_tot = '0;
		sh_free_tot  = '0;
		relink_pool();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// The link RAM is cleared after reset; wait until the input opens.
		@(posedge clk);
		while (!s_tready) @(posedge clk);

		// Default pool: pops, pushes, freeing into a full free list, bad offsets.
		queue_cmd(ACT_ALLOC, 32'hFFFF_FFFF);
		queue_cmd(ACT_ALLOC, 32'h0);
		queue_cmd(ACT_FREE, 32'd8);
		queue_cmd(ACT_FREE, 32'd0);
		queue_cmd(ACT_FREE, 32'd0);
		queue_cmd(ACT_FREE, 32'd3);
		queue_cmd(ACT_FREE, 32'd8192);
		queue_cmd(ACT_FREE, 32'hFFFF_FFFF);
		queue_cmd(ACT_UNUSED, 32'h5A5A_A5A5);
		queue_cmd(ACT_FREE, 32'd8184);
		drain();

		// Largest blocks and a block count above the pool: the top block offset.
		write_reg(REG_BLOCK_BYTES, 13'd4096);
		write_reg(REG_BLOCK_COUNT, 13'd2047);
		queue_cmd(ACT_REBUILD, 32'h0);
		queue_cmd(ACT_ALLOC, 32'h0);
		queue_cmd(ACT_FREE, 32'd4190208);
		queue_cmd(ACT_ALLOC, 32'h0);
		queue_cmd(ACT_FREE, 32'd4194304);
		drain();

		// Block size below the minimum and a zero block count: a one-block pool.
		write_reg(REG_BLOCK_BYTES, 13'd0);
		write_reg(REG_BLOCK_COUNT, 13'd0);
		queue_cmd(ACT_REBUILD, 32'h0);
		queue_cmd(ACT_ALLOC, 32'h0);
		queue_cmd(ACT_ALLOC, 32'h0);
		queue_cmd(ACT_FREE, 32'd8);
		queue_cmd(ACT_FREE, 32'd0);
		queue_cmd(ACT_FREE, 32'd0);
		drain();

		// Random phases, each under a fresh setting.
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0) write_reg(REG_BLOCK_BYTES, pick_block_bytes());
			if ($urandom_range(0, 3) != 0) write_reg(REG_BLOCK_COUNT, pick_block_count());
			if ($urandom_range(0, 4) != 0) queue_cmd(ACT_REBUILD, $urandom());
			phase_len = $urandom_range(20, 80);
			queue_random_phase(phase_len);
			random_items += phase_len;
			drain();
		end
		repeat (40) @(posedge clk);

		$display("Checked %0d of %0d result beats over %0d register writes and %0d rebuilds.",
			beats_checked, beats_sent, cfg_writes, rebuilds);
		$display("Statuses ok %0d, full %0d, bad offset %0d, nothing to free %0d; %0d hold-offs.",
			status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_BAD_OFFSET],
			status_hits[ST_NOTHING], holds_done);
		if (mismatches == 0 && outcome_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches, outcome_q.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/fbpa_pkg.sv
rtl/fbpa_link_ram.sv
rtl/fbpa_divider.sv
rtl/fixed_block_pool_allocator.sv
test/tb_fixed_block_pool_allocator.sv
